// ----- rtl/core/stc_pkg.sv -----
// Shared types, codes and constants of the separator-class tokenizer.
// No dependencies; every other file of the block depends on this package.
package stc_pkg;

    localparam int SET_SLOTS      = 8;
    localparam int SET_W          = 64;
    localparam int WORDS_W        = 11;
    localparam int BYTES_W        = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int QUEUE_DEPTH_D  = 2;
    localparam int NUM_OPS        = 5;
    localparam int OP_IDX_W       = 3;

    localparam logic [WORDS_W-1:0] MAX_WORDS_RST = 11'd256;
    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 16'd4096;

    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_SET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_SET   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEGIN_SET  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_SET    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WORDS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES  = 3'd5;

    // step slots of one queued byte, in execution order
    localparam logic [OP_IDX_W-1:0] OP_PRE_CLOSE  = 3'd0;
    localparam logic [OP_IDX_W-1:0] OP_APPEND     = 3'd1;
    localparam logic [OP_IDX_W-1:0] OP_POST_CLOSE = 3'd2;
    localparam logic [OP_IDX_W-1:0] OP_LINE_CLOSE = 3'd3;
    localparam logic [OP_IDX_W-1:0] OP_LINE_DONE  = 3'd4;

    typedef enum logic [1:0] {
        EV_APPEND    = 2'd0,
        EV_WORD_END  = 2'd1,
        EV_LINE_DONE = 2'd2
    } stc_kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } stc_in_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [7:0]         out_byte;
        logic [WORDS_W-1:0] words_so_far;
        logic               truncated;
        logic               last_of_run;
    } stc_event_t;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] text_byte;
        logic       pre_close;
        logic       append;
        logic       post_close;
        logic       opens;
        logic       line_end;
    } stc_op_t;

    typedef struct packed {
        logic [SET_W-1:0] skip_set;
        logic [SET_W-1:0] keep_set;
        logic [SET_W-1:0] begin_set;
        logic [SET_W-1:0] end_set;
    } stc_sets_t;

    function automatic logic in_set(input logic [SET_W-1:0] set, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            if (set[8*i +: 8] != 8'd0 && set[8*i +: 8] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- rtl/core/stc_if.sv -----
// Valid/ready channel interfaces for input bytes and result events.
// Depends on stc_pkg for the payload structs.
interface stc_in_if;
    logic             valid;
    logic             ready;
    stc_pkg::stc_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface stc_out_if;
    logic                valid;
    logic                ready;
    stc_pkg::stc_event_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/stc_front.sv -----
// Front end: accepts input bytes and classifies them against the separator sets.
// Depends on stc_pkg and stc_in_if.
module stc_front (
    stc_in_if.sink        byte_in,
    input  stc_pkg::stc_sets_t sets,
    input  logic          queue_full,
    output logic          push,
    output stc_pkg::stc_op_t   op
);
    import stc_pkg::*;

    logic is_skip;
    logic is_keep;
    logic is_begin;
    logic is_end;

    assign byte_in.ready = !queue_full;
    assign push          = byte_in.valid && !queue_full;

    assign is_skip  = in_set(sets.skip_set,  byte_in.payload.text_byte);
    assign is_keep  = in_set(sets.keep_set,  byte_in.payload.text_byte);
    assign is_begin = in_set(sets.begin_set, byte_in.payload.text_byte);
    assign is_end   = in_set(sets.end_set,   byte_in.payload.text_byte);

    always_comb
    begin
        op.text_byte  = byte_in.payload.text_byte;
        op.line_end   = byte_in.payload.line_end;
        op.pre_close  = 1'b0;
        op.append     = 1'b1;
        op.post_close = 1'b0;
        op.opens      = 1'b1;
        if (is_skip)
        begin
            op.pre_close = 1'b1;
            op.append    = 1'b0;
            op.opens     = 1'b0;
        end
        else if (is_keep)
        begin
            op.pre_close  = 1'b1;
            op.post_close = 1'b1;
            op.opens      = 1'b0;
        end
        else if (is_begin)
        begin
            op.pre_close = 1'b1;
        end
        else if (is_end)
        begin
            op.post_close = 1'b1;
            op.opens      = 1'b0;
        end
    end

endmodule

// ----- rtl/core/stc_queue.sv -----
// Short register queue between the classifier and the event sequencer.
// Depends on stc_pkg for the entry type.
module stc_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stc_pkg::stc_op_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output stc_pkg::stc_op_t head
);
    import stc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stc_op_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/stc_back.sv -----
// Back end: steps through each queued byte's actions, one event a cycle unless
// stalled; keeps word and byte counts and the output register; uses stc_pkg.
module stc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  stc_pkg::stc_op_t            head,
    input  logic [stc_pkg::WORDS_W-1:0] max_words,
    input  logic [stc_pkg::BYTES_W-1:0] max_result_bytes,
    output logic                        pop,
    stc_out_if.source                   event_out
);
    import stc_pkg::*;

    logic               inside_reg, inside_next;
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic               stopped_reg, stopped_next;
    logic [NUM_OPS-1:0] done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    stc_event_t         out_reg, out_next;

    logic [NUM_OPS-1:0]  pend;
    logic [NUM_OPS-1:0]  cand;
    logic [NUM_OPS-1:0]  thru;
    logic [NUM_OPS-1:0]  rem;
    logic [OP_IDX_W-1:0] sel;
    logic                has_op;
    logic                is_close;
    logic                is_done;
    logic [WORDS_W-1:0]  words_inc;
    logic [BYTES_W-1:0]  bytes_inc;
    logic                hit_limit;
    logic                ev_stopped;
    logic                ev_inside;
    logic                more;
    logic                out_free;
    logic                fire;

    assign pend = {head.line_end, head.line_end, head.post_close, head.append, head.pre_close}
                  & ~done_reg;

    always_comb
    begin
        cand                = '0;
        cand[OP_PRE_CLOSE]  = pend[OP_PRE_CLOSE] && !stopped_reg && inside_reg;
        cand[OP_APPEND]     = pend[OP_APPEND] && !stopped_reg;
        cand[OP_POST_CLOSE] = pend[OP_POST_CLOSE] && !stopped_reg;
        cand[OP_LINE_CLOSE] = pend[OP_LINE_CLOSE] && !stopped_reg && inside_reg;
        cand[OP_LINE_DONE]  = pend[OP_LINE_DONE];
    end

    always_comb
    begin
        sel = OP_LINE_DONE;
        for (int i = NUM_OPS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                sel = OP_IDX_W'(i);
            end
        end
        for (int i = 0; i < NUM_OPS; i++)
        begin
            thru[i] = (OP_IDX_W'(i) <= sel);
        end
    end

    assign has_op   = |cand;
    assign rem      = pend & ~thru;
    assign is_done  = (sel == OP_LINE_DONE);
    assign is_close = (sel == OP_PRE_CLOSE) || (sel == OP_POST_CLOSE) || (sel == OP_LINE_CLOSE);

    assign words_inc  = words_reg + WORDS_W'(is_close);
    assign bytes_inc  = bytes_reg + 1'b1;
    assign hit_limit  = (words_inc >= max_words) || (bytes_inc >= max_result_bytes);
    assign ev_stopped = stopped_reg || (!is_done && hit_limit);
    assign ev_inside  = (sel == OP_APPEND) ? head.opens : 1'b0;

    assign more = !is_done && (rem[OP_LINE_DONE]
                  || (!ev_stopped && (rem[OP_APPEND] || rem[OP_POST_CLOSE]
                  || (rem[OP_LINE_CLOSE] && ev_inside))));

    assign out_free = !out_valid_reg || event_out.ready;
    assign fire     = head_valid && has_op && out_free;
    assign pop      = head_valid && (!has_op || (fire && !more));

    always_comb
    begin
        inside_next    = inside_reg;
        words_next     = words_reg;
        bytes_next     = bytes_reg;
        stopped_next   = stopped_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !event_out.ready;
        out_next       = out_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_next.last_of_run = !more;
            if (is_done)
            begin
                out_next.event_kind   = EV_LINE_DONE;
                out_next.out_byte     = 8'd0;
                out_next.words_so_far = words_reg;
                out_next.truncated    = stopped_reg;
                inside_next  = 1'b0;
                words_next   = '0;
                bytes_next   = '0;
                stopped_next = 1'b0;
            end
            else
            begin
                out_next.event_kind   = is_close ? EV_WORD_END : EV_APPEND;
                out_next.out_byte     = is_close ? 8'd0 : head.text_byte;
                out_next.words_so_far = words_inc;
                out_next.truncated    = ev_stopped;
                inside_next  = ev_inside;
                words_next   = words_inc;
                bytes_next   = bytes_inc;
                stopped_next = ev_stopped;
            end
            done_next = done_reg | thru;
        end
        if (pop)
        begin
            done_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            words_reg     <= '0;
            bytes_reg     <= '0;
            stopped_reg   <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inside_reg    <= inside_next;
            words_reg     <= words_next;
            bytes_reg     <= bytes_next;
            stopped_reg   <= stopped_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign event_out.valid   = out_valid_reg;
    assign event_out.payload = out_reg;

endmodule

// ----- rtl/core/separator_class_tokenizer_core.sv -----
// Top level of the separator-class tokenizer: register file, classifier front,
// byte queue and event sequencer. Uses stc_pkg, stc_if, stc_front/queue/back.
//
// Usage:
//   byte_in carries one text byte per beat with line_end on the line's last byte.
//   event_out carries one event per beat: byte appended, word ended or line done,
//   with the running word count, the truncation flag and last_of_run on the last
//   event a byte causes. cfg_we/cfg_index/cfg_data write the four separator sets
//   and the two per-line limits; write them only while no line is in flight.
//   The first event of a byte is registered in the queue entry and then in the
//   output register. A byte stays in the sequencer while it emits the events it
//   causes (one to four), one event per cycle while event_out is not stalled,
//   and leaves with no event when it causes none; plain word bytes run at one per
//   cycle while not stalled; the sequencer has a single event slot per cycle.
//   Reset clears the line state, the queue and the output valid flag and loads
//   the default limits (256 words, 4096 result bytes) and empty sets.
//   When event_out stalls, the output register holds its beat, the sequencer
//   waits, and the queue keeps taking bytes until it fills.
module separator_class_tokenizer_core #(
    parameter int QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH_D
) (
    input  logic                            clk,
    input  logic                            rst_n,
    stc_in_if.sink                          byte_in,
    stc_out_if.source                       event_out,
    input  logic                            cfg_we,
    input  logic [stc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stc_pkg::SET_W-1:0]       cfg_data
);
    import stc_pkg::*;

    stc_sets_t          sets_reg;
    logic [WORDS_W-1:0] max_words_reg;
    logic [BYTES_W-1:0] max_bytes_reg;

    logic    push;
    logic    pop;
    logic    queue_full;
    logic    head_valid;
    stc_op_t push_op;
    stc_op_t head_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_reg      <= '0;
            max_words_reg <= MAX_WORDS_RST;
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SKIP_SET:  sets_reg.skip_set  <= cfg_data;
                CFG_KEEP_SET:  sets_reg.keep_set  <= cfg_data;
                CFG_BEGIN_SET: sets_reg.begin_set <= cfg_data;
                CFG_END_SET:   sets_reg.end_set   <= cfg_data;
                CFG_MAX_WORDS: max_words_reg <= cfg_data[WORDS_W-1:0];
                CFG_MAX_BYTES: max_bytes_reg <= cfg_data[BYTES_W-1:0];
                default:       ;
            endcase
        end
    end

    stc_front u_front (
        .byte_in    (byte_in),
        .sets       (sets_reg),
        .queue_full (queue_full),
        .push       (push),
        .op         (push_op)
    );

    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_op),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head_op)
    );

    stc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head             (head_op),
        .max_words        (max_words_reg),
        .max_result_bytes (max_bytes_reg),
        .pop              (pop),
        .event_out        (event_out)
    );

endmodule

// ----- rtl/core/stc_checker.sv -----
// Port-level checks on the tokenizer's event channel, bound to the top level.
// Depends on stc_pkg and separator_class_tokenizer_core.
module stc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input stc_pkg::stc_event_t out_payload
);
    import stc_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("stalled event beat changed");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.event_kind != EV_APPEND |-> out_payload.out_byte == 8'd0)
        else $error("non-append event carries a byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.event_kind == EV_LINE_DONE |-> out_payload.last_of_run)
        else $error("line-done event not last of its run");

    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.event_kind == EV_WORD_END |-> out_payload.words_so_far != '0)
        else $error("word end with zero word count");

endmodule

bind separator_class_tokenizer_core stc_checker u_stc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (event_out.valid),
    .out_ready   (event_out.ready),
    .out_payload (event_out.payload)
);
